// ===== rtl/hcq_pkg.sv =====
// ----------------------------------------------------------------------------
// hcq_pkg
// Shared types and constants for the EMG hysteresis command qualifier.
// ----------------------------------------------------------------------------
`default_nettype none

package hcq_pkg;

  localparam int unsigned DataW  = 8;
  localparam int unsigned ShiftW = 3;
  localparam int unsigned IndexW = 3;

  // Register indexes of the configuration port.
  localparam logic [IndexW-1:0] RegBaseline     = 3'd0;
  localparam logic [IndexW-1:0] RegCloseDelta   = 3'd1;
  localparam logic [IndexW-1:0] RegOpenDelta    = 3'd2;
  localparam logic [IndexW-1:0] RegSmoothShift  = 3'd3;
  localparam logic [IndexW-1:0] RegConfirmCount = 3'd4;

  // Reset values.
  localparam logic [DataW-1:0]  BaselineRst     = 8'd128;
  localparam logic [DataW-1:0]  CloseDeltaRst   = 8'd12;
  localparam logic [DataW-1:0]  OpenDeltaRst    = 8'd8;
  localparam logic [ShiftW-1:0] SmoothShiftRst  = 3'd2;
  localparam logic [DataW-1:0]  ConfirmCountRst = 8'd3;
  localparam logic [DataW-1:0]  LevelRst        = 8'd128;

  localparam logic [DataW-1:0]  CloseCap        = 8'd250;
  localparam logic [DataW-1:0]  CountMax        = 8'd255;

  typedef enum logic [1:0] {
    CMD_HOLD  = 2'd0,
    CMD_OPEN  = 2'd1,
    CMD_CLOSE = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [DataW-1:0]  baseline;
    logic [DataW-1:0]  close_delta;
    logic [DataW-1:0]  open_delta;
    logic [ShiftW-1:0] smooth_shift;
    logic [DataW-1:0]  confirm_count;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/hcq_cfg.sv =====
// ----------------------------------------------------------------------------
// hcq_cfg
// Configuration register file, written through a valid/ready channel.
// ----------------------------------------------------------------------------
`default_nettype none

module hcq_cfg
  import hcq_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_valid_i,
  input  wire logic [IndexW-1:0] cfg_index_i,
  input  wire logic [DataW-1:0]  cfg_data_i,
  output cfg_t                   cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.baseline      <= BaselineRst;
      cfg_q.close_delta   <= CloseDeltaRst;
      cfg_q.open_delta    <= OpenDeltaRst;
      cfg_q.smooth_shift  <= SmoothShiftRst;
      cfg_q.confirm_count <= ConfirmCountRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegBaseline:     cfg_q.baseline      <= cfg_data_i;
        RegCloseDelta:   cfg_q.close_delta   <= cfg_data_i;
        RegOpenDelta:    cfg_q.open_delta    <= cfg_data_i;
        RegSmoothShift:  cfg_q.smooth_shift  <= cfg_data_i[ShiftW-1:0];
        RegConfirmCount: cfg_q.confirm_count <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/hcq_core.sv =====
// ----------------------------------------------------------------------------
// hcq_core
// IIR smoothing, hysteresis thresholds and confirm counters.
// ----------------------------------------------------------------------------
`default_nettype none

module hcq_core
  import hcq_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cfg_t             cfg_i,
  input  wire logic             commit_i,
  input  wire logic [DataW-1:0] sample_i,
  output cmd_e                  command_o,
  output logic      [DataW-1:0] level_o
);

  logic [DataW-1:0] level_q, level_d;
  logic [DataW-1:0] above_q, above_d;
  logic [DataW-1:0] below_q, below_d;

  logic signed [DataW:0]   diff;
  logic signed [DataW:0]   step;
  logic signed [DataW:0]   level_sum;
  logic        [DataW:0]   close_sum;
  logic signed [DataW+1:0] close_t;
  logic signed [DataW+1:0] open_raw;
  logic signed [DataW+1:0] open_t;
  logic signed [DataW+1:0] lv_s;
  logic        [DataW-1:0] above_inc;
  logic        [DataW-1:0] below_inc;

  // Arithmetic right shift gives the floor of the division for both signs.
  assign diff      = $signed({1'b0, sample_i}) - $signed({1'b0, level_q});
  assign step      = diff >>> cfg_i.smooth_shift;
  assign level_sum = $signed({1'b0, level_q}) + step;
  assign level_d   = level_sum[DataW-1:0];
  assign level_o   = level_d;

  assign close_sum = {1'b0, cfg_i.baseline} + {1'b0, cfg_i.close_delta};
  assign close_t   = (close_sum > {1'b0, CloseCap}) ? $signed({2'b00, CloseCap})
                                                    : $signed({1'b0, close_sum});
  assign open_raw  = $signed({2'b00, cfg_i.baseline}) - $signed({2'b00, cfg_i.open_delta});

  always_comb begin
    open_t = open_raw;
    if (open_t < 0) open_t = '0;
    // With a close threshold of zero this yields -1, so open is unreachable.
    if (open_t >= close_t) open_t = close_t - 10'sd1;
  end

  assign lv_s      = $signed({2'b00, level_d});
  assign above_inc = (above_q == CountMax) ? above_q : above_q + 8'd1;
  assign below_inc = (below_q == CountMax) ? below_q : below_q + 8'd1;

  always_comb begin
    command_o = CMD_HOLD;
    above_d   = '0;
    below_d   = '0;
    if (lv_s > close_t) begin
      above_d = above_inc;
      if (above_inc >= cfg_i.confirm_count) begin
        command_o = CMD_CLOSE;
        above_d   = '0;
      end
    end else if (lv_s < open_t) begin
      below_d = below_inc;
      if (below_inc >= cfg_i.confirm_count) begin
        command_o = CMD_OPEN;
        below_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= LevelRst;
      above_q <= '0;
      below_q <= '0;
    end else if (commit_i) begin
      level_q <= level_d;
      above_q <= above_d;
      below_q <= below_d;
    end
  end

  a_counters_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(above_q != '0 && below_q != '0))
    else $error("above and below counters both nonzero");

  a_close_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit_i && command_o == CMD_CLOSE) |=> (above_q == '0 && below_q == '0))
    else $error("close command did not clear the counters");

  a_open_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit_i && command_o == CMD_OPEN) |=> (above_q == '0 && below_q == '0))
    else $error("open command did not clear the counters");

  a_level_between: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit_i |-> ((level_d >= level_q && level_d <= sample_i) ||
                  (level_d <= level_q && level_d >= sample_i)))
    else $error("filtered level left the span of old level and sample");

endmodule

`default_nettype wire

// ===== rtl/emg_hysteresis_command_qualifier_top.sv =====
// ----------------------------------------------------------------------------
// emg_hysteresis_command_qualifier_top
// EMG sample smoother with hysteresis thresholds and confirmed open/close.
// ----------------------------------------------------------------------------
// One sample is taken per cycle while the input is not stalled, and each yields
// exactly one result: the sample lands in an input register, the filter,
// threshold and counter update is combinational, and the result sits in an
// output register. A new sample can be accepted every cycle unless the input
// is stalled by a blocked result; the state update of one sample feeds the
// next. The configuration port is always ready and should be written
// only while no samples are in flight.
`default_nettype none

module emg_hysteresis_command_qualifier_top
  import hcq_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [DataW-1:0]  sample_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic      [1:0]        command_o,
  output logic      [DataW-1:0]  smoothed_level_o,
  output logic      [DataW-1:0]  sample_echo_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [IndexW-1:0] cfg_index_i,
  input  wire logic [DataW-1:0]  cfg_data_i
);

  cfg_t             cfg;
  logic             s1_valid_q;
  logic [DataW-1:0] s1_sample_q;
  logic             advance;
  logic             commit;
  cmd_e             core_cmd;
  logic [DataW-1:0] core_level;
  logic             out_valid_q;
  logic [1:0]       cmd_q;
  logic [DataW-1:0] level_q;
  logic [DataW-1:0] echo_q;

  assign cfg_ready_o = 1'b1;

  hcq_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // The result register frees when empty or when its transaction completes.
  assign advance    = !out_valid_q || !out_stall_i;
  assign commit     = s1_valid_q && advance;
  assign in_stall_o = s1_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      s1_sample_q <= sample_i;
    end
  end

  hcq_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .commit_i  (commit),
    .sample_i  (s1_sample_q),
    .command_o (core_cmd),
    .level_o   (core_level)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      cmd_q   <= core_cmd;
      level_q <= core_level;
      echo_q  <= s1_sample_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign command_o        = cmd_q;
  assign smoothed_level_o = level_q;
  assign sample_echo_o    = echo_q;

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without a blocked result");

  a_commit_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> out_valid_q)
    else $error("committed transaction did not reach the result register");

  a_no_reserved_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (command_o == CMD_HOLD || command_o == CMD_OPEN ||
                     command_o == CMD_CLOSE))
    else $error("reserved command code on the output");

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the EMG hysteresis command qualifier. Samples are
// driven with random gaps against a randomly stalled output; a scoreboard
// predicts the smoothed level, the confirm counters and the command of every
// accepted sample and checks each result in order.
// ----------------------------------------------------------------------------

module tb;
  import hcq_pkg::*;

  // Indexes past the register list; writes there must change nothing.
  localparam logic [IndexW-1:0] RegSpareLo = 3'd5;
  localparam logic [IndexW-1:0] RegSpareHi = 3'd7;

  typedef struct {
    cmd_e             command;
    logic [DataW-1:0] level;
    logic [DataW-1:0] echo;
  } qualifier_result_t;

  class qualifier_scoreboard;
    logic [DataW-1:0]  baseline;
    logic [DataW-1:0]  close_delta;
    logic [DataW-1:0]  open_delta;
    logic [ShiftW-1:0] smooth_shift;
    logic [DataW-1:0]  confirm_count;
    logic [DataW-1:0]  level;
    logic [DataW-1:0]  above_cnt;
    logic [DataW-1:0]  below_cnt;
    qualifier_result_t expected_q[$];
    int unsigned       n_samples;
    int unsigned       n_results;
    int unsigned       n_close;
    int unsigned       n_open;

    function new();
      baseline      = BaselineRst;
      close_delta   = CloseDeltaRst;
      open_delta    = OpenDeltaRst;
      smooth_shift  = SmoothShiftRst;
      confirm_count = ConfirmCountRst;
      level         = LevelRst;
      above_cnt     = '0;
      below_cnt     = '0;
      n_samples     = 0;
      n_results     = 0;
      n_close       = 0;
      n_open        = 0;
    endfunction

    function void write_reg(logic [IndexW-1:0] idx, logic [DataW-1:0] data);
      case (idx)
        RegBaseline:     baseline      = data;
        RegCloseDelta:   close_delta   = data;
        RegOpenDelta:    open_delta    = data;
        RegSmoothShift:  smooth_shift  = data[ShiftW-1:0];
        RegConfirmCount: confirm_count = data;
        default: ;
      endcase
    endfunction

    function void note_sample(logic [DataW-1:0] smp);
      int diff;
      int next_lv;
      int close_t;
      int open_t;
      qualifier_result_t res;
      // An arithmetic shift of a signed int rounds toward minus infinity.
      diff    = int'(smp) - int'(level);
      next_lv = int'(level) + (diff >>> smooth_shift);
      level   = next_lv[DataW-1:0];
      close_t = int'(baseline) + int'(close_delta);
      if (close_t > int'(CloseCap)) close_t = int'(CloseCap);
      open_t = int'(baseline) - int'(open_delta);
      if (open_t < 0) open_t = 0;
      if (open_t >= close_t) open_t = close_t - 1;
      res.command = CMD_HOLD;
      if (next_lv > close_t) begin
        if (above_cnt != CountMax) above_cnt++;
        below_cnt = '0;
        if (above_cnt >= confirm_count) begin
          res.command = CMD_CLOSE;
          above_cnt   = '0;
        end
      end else if (next_lv < open_t) begin
        if (below_cnt != CountMax) below_cnt++;
        above_cnt = '0;
        if (below_cnt >= confirm_count) begin
          res.command = CMD_OPEN;
          below_cnt   = '0;
        end
      end else begin
        above_cnt = '0;
        below_cnt = '0;
      end
      res.level = level;
      res.echo  = smp;
      expected_q.push_back(res);
      n_samples++;
    endfunction

    // Returns an empty string when the result matches the oldest expectation.
    function string check_result(logic [1:0] cmd, logic [DataW-1:0] lvl,
                                 logic [DataW-1:0] echo);
      qualifier_result_t exp_res;
      string msg;
      if (expected_q.size() == 0) return "result arrived with nothing expected";
      exp_res = expected_q.pop_front();
      n_results++;
      if (exp_res.command == CMD_CLOSE) n_close++;
      if (exp_res.command == CMD_OPEN) n_open++;
      msg = "";
      if (cmd !== exp_res.command)
        msg = {msg, $sformatf(" command %0d/%0d", cmd, exp_res.command)};
      if (lvl !== exp_res.level)
        msg = {msg, $sformatf(" level %0d/%0d", lvl, exp_res.level)};
      if (echo !== exp_res.echo)
        msg = {msg, $sformatf(" echo %0d/%0d", echo, exp_res.echo)};
      if (msg != "") msg = {$sformatf("result %0d got/exp:", n_results), msg};
      return msg;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [DataW-1:0]  sample_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [1:0]        command_o;
  logic [DataW-1:0]  smoothed_level_o;
  logic [DataW-1:0]  sample_echo_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [IndexW-1:0] cfg_index_i = '0;
  logic [DataW-1:0]  cfg_data_i = '0;

  qualifier_scoreboard sb = new();
  int unsigned errors = 0;
  int unsigned n_settings = 0;
  bit          calm = 1'b0;
  string       cmp_msg;

  emg_hysteresis_command_qualifier_top uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .sample_i         (sample_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .command_o        (command_o),
    .smoothed_level_o (smoothed_level_o),
    .sample_echo_o    (sample_echo_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #1_000_000;
    $display("FAIL");
    $finish;
  end

  task automatic report_mismatch(string what);
    $display("mismatch at %0t ns: %s", $time, what);
    errors++;
  endtask

  // Mostly short idle stretches, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Every transaction on all three channels is observed here.
  always @(posedge clk_i) begin
    if (cfg_valid_i && cfg_ready_o) sb.write_reg(cfg_index_i, cfg_data_i);
    if (in_valid_i && !in_stall_o) sb.note_sample(sample_i);
    if (out_valid_o && !out_stall_i) begin
      cmp_msg = sb.check_result(command_o, smoothed_level_o, sample_echo_o);
      if (cmp_msg != "") report_mismatch(cmp_msg);
    end
  end

  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (calm) begin
        out_stall_i <= 1'b0;
        hold_left = 0;
      end else if (hold_left > 0) begin
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(0, 2) == 0);
        hold_left = idle_len();
      end
    end
  end

  task automatic push_sample(logic [DataW-1:0] smp);
    repeat (idle_len()) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    sample_i   <= smp;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Stops the sample stream and waits until every result has come back.
  task automatic hold_until_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [IndexW-1:0] idx, logic [DataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic set_config(logic [DataW-1:0] base, logic [DataW-1:0] cd,
                            logic [DataW-1:0] od, logic [DataW-1:0] sh,
                            logic [DataW-1:0] cc);
    write_reg(RegBaseline, base);
    write_reg(RegCloseDelta, cd);
    write_reg(RegOpenDelta, od);
    write_reg(RegSmoothShift, sh);
    write_reg(RegConfirmCount, cc);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    n_settings++;
  endtask

  initial begin
    int unsigned run_left;
    int unsigned mode;
    int unsigned n_items;
    int          v;
    logic [DataW-1:0] smp;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset thresholds: burst then decay confirm close twice, silence opens.
    repeat (5) push_sample(8'd255);
    repeat (7) push_sample(8'd0);
    push_sample(8'h55);
    push_sample(8'hAA);
    hold_until_drained();

    // Baseline above its range, open forced below the capped close, and a
    // zero shift so the level tracks the sample exactly.
    set_config(8'd255, 8'd0, 8'd0, 8'hF8, 8'd1);
    push_sample(8'd255);
    push_sample(8'd251);
    push_sample(8'd250);
    push_sample(8'd249);
    push_sample(8'd248);
    push_sample(8'd0);
    hold_until_drained();

    // Close threshold of zero leaves open unreachable; confirm of zero acts
    // as one. The shift write carries junk above its three bits.
    set_config(8'd0, 8'd0, 8'd255, 8'hFF, 8'd0);
    push_sample(8'd0);
    push_sample(8'd255);
    push_sample(8'd1);
    hold_until_drained();
    for (int k = RegSpareLo; k <= RegSpareHi; k++)
      write_reg(IndexW'(k), 8'($urandom()));
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    push_sample(8'd128);
    hold_until_drained();

    set_config(8'd245, 8'd255, 8'd0, 8'd7, 8'd255);
    push_sample(8'd255);
    push_sample(8'd255);
    hold_until_drained();

    run_left = 0;
    mode = 0;
    for (int ph = 0; ph < 9; ph++) begin
      calm = (ph % 4 == 2);
      set_config(($urandom_range(0, 9) == 0) ? 8'($urandom())
                                             : 8'($urandom_range(10, 245)),
                 ($urandom_range(0, 9) == 0) ? 8'($urandom())
                                             : 8'($urandom_range(0, 40)),
                 ($urandom_range(0, 9) == 0) ? 8'($urandom())
                                             : 8'($urandom_range(0, 40)),
                 {5'($urandom()), ($urandom_range(0, 4) == 0)
                                    ? 3'($urandom_range(4, 7))
                                    : 3'($urandom_range(0, 3))},
                 ($urandom_range(0, 19) == 0) ? 8'd0 :
                 ($urandom_range(0, 19) == 0) ? 8'd255 :
                                                8'($urandom_range(1, 6)));
      n_items = $urandom_range(45, 65);
      for (int i = 0; i < n_items; i++) begin
        // Bursts of strong or weak activity drive the confirm counters.
        if (run_left == 0) begin
          v = $urandom_range(0, 99);
          mode = (v < 35) ? 0 : (v < 70) ? 1 : (v < 85) ? 2 : 3;
          run_left = $urandom_range(1, 12);
        end
        run_left--;
        case (mode)
          0: smp = 8'($urandom_range(200, 255));
          1: smp = 8'($urandom_range(0, 50));
          2: begin
            v = int'(sb.baseline) + int'($urandom_range(0, 40)) - 20;
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            smp = 8'(v);
          end
          default: smp = 8'($urandom());
        endcase
        push_sample(smp);
        if ((ph == 1 && i == 20) || $urandom_range(0, 99) == 0)
          hold_until_drained();
      end
      hold_until_drained();
    end
    calm = 1'b1;

    repeat (8) @(posedge clk_i);
    $display("%0d samples sent, %0d results checked (%0d close, %0d open)",
             sb.n_samples, sb.n_results, sb.n_close, sb.n_open);
    $display("%0d register settings applied, spare indexes written once",
             n_settings);
    if (errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
